// ===== hdl/mts_pkg.sv =====
package mts_pkg;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 6;
    localparam int NOTE_W     = 6;
    localparam int BEATS_W    = 8;
    localparam int DIV_W      = 8;
    localparam int LEN_W      = 7;
    localparam int TMR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SONG_DEPTH_DEF = 64;
    localparam int NOTE_COUNT     = 36;
    localparam int ROM_SIZE       = 36;
    localparam int NOTE_LIM       = (NOTE_COUNT < ROM_SIZE) ? NOTE_COUNT : ROM_SIZE;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_DIVIDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_BASE    = 2'd2;

    localparam logic [DIV_W-1:0] DIV_RST  = 8'd8;
    localparam logic [LEN_W-1:0] LEN_RST  = 7'd42;
    localparam logic [TMR_W-1:0] BASE_RST = 16'h3CAF;
    localparam logic [TMR_W-1:0] TMR_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [NOTE_W-1:0]  note;
        logic [BEATS_W-1:0] beats;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   idx;
        logic [NOTE_W-1:0]  note;
        logic [BEATS_W-1:0] beats;
    } t_item;

    typedef struct packed {
        logic [DIV_W-1:0] divider;
        logic [LEN_W-1:0] length;
        logic [TMR_W-1:0] base;
    } t_cfg;

    typedef struct packed {
        logic              level;
        logic [NOTE_W-1:0] note;
        logic              beat;
    } t_result;

    function automatic logic [NOTE_W-1:0] clamp_note(input logic [NOTE_W-1:0] n);
        logic [NOTE_W-1:0] lim;
        lim = NOTE_W'(NOTE_LIM);
        return (n >= lim) ? NOTE_W'(NOTE_LIM - 1) : n;
    endfunction

    // tone counter reload per note
    function automatic logic [TMR_W-1:0] tone_rom(input logic [NOTE_W-1:0] n);
        logic [TMR_W-1:0] v;
        case (n)
            6'd0:    v = 16'hEFA9;
            6'd1:    v = 16'hF093;
            6'd2:    v = 16'hF173;
            6'd3:    v = 16'hF249;
            6'd4:    v = 16'hF307;
            6'd5:    v = 16'hF3C8;
            6'd6:    v = 16'hF473;
            6'd7:    v = 16'hF51E;
            6'd8:    v = 16'hF5B6;
            6'd9:    v = 16'hF64C;
            6'd10:   v = 16'hF6D7;
            6'd11:   v = 16'hF75A;
            6'd12:   v = 16'hF7D8;
            6'd13:   v = 16'hF84D;
            6'd14:   v = 16'hF8BD;
            6'd15:   v = 16'hF924;
            6'd16:   v = 16'hF987;
            6'd17:   v = 16'hF9E4;
            6'd18:   v = 16'hFA3D;
            6'd19:   v = 16'hFA90;
            6'd20:   v = 16'hFADE;
            6'd21:   v = 16'hFB29;
            6'd22:   v = 16'hFB6F;
            6'd23:   v = 16'hFBB1;
            6'd24:   v = 16'hFBEF;
            6'd25:   v = 16'hFC2A;
            6'd26:   v = 16'hFC62;
            6'd27:   v = 16'hFC95;
            6'd28:   v = 16'hFCC7;
            6'd29:   v = 16'hFCF6;
            6'd30:   v = 16'hFD22;
            6'd31:   v = 16'hFD4B;
            6'd32:   v = 16'hFD73;
            6'd33:   v = 16'hFD98;
            6'd34:   v = 16'hFDBB;
            default: v = 16'hFDDC;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/melody_tone_sequencer_core.sv =====
// Channel  Handshake                  Word
// in       i_in_valid / o_in_stall    i_kind, i_entry_index, i_entry_note, i_entry_beats
// out      o_out_valid / i_out_stall  o_tone_level, o_song_position, o_current_note,
//                                     o_beat_event
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per clock unless o_in_stall is high; each input word yields one output word
// through the input register, then the result register. The song store is a RAM with
// registered read, so the next entry is fetched ahead of use; after a configuration write
// the input register holds its word while that fetch catches up.
// Reset is synchronous, active low; the song store is not cleared.
// A stalled output still lets one more input word enter the input register.
module melody_tone_sequencer_core #(
    parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mts_pkg::KIND_W-1:0]      i_kind,
    input  logic [mts_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [mts_pkg::NOTE_W-1:0]      i_entry_note,
    input  logic [mts_pkg::BEATS_W-1:0]     i_entry_beats,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_tone_level,
    output logic [$clog2(SONG_DEPTH)-1:0]   o_song_position,
    output logic [mts_pkg::NOTE_W-1:0]      o_current_note,
    output logic                            o_beat_event,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mts_pkg::*;

    localparam int PW = $clog2(SONG_DEPTH);

    logic          r_in_vld;
    t_item         r_in_item;
    logic          r_out_vld;
    t_result       r_out_res;
    logic [PW-1:0] r_out_pos;

    t_cfg          cfg;
    logic          cfg_hold;
    logic          go;
    t_result       res;
    logic [PW-1:0] pos;

    mts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_hold      (cfg_hold)
    );

    mts_core #(
        .SONG_DEPTH (SONG_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (res),
        .o_pos   (pos)
    );

    // advance when no configuration hold is pending and the result register is free or being drained
    assign go         = r_in_vld && !cfg_hold && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
            if (go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item.kind  <= i_kind;
            r_in_item.idx   <= i_entry_index;
            r_in_item.note  <= i_entry_note;
            r_in_item.beats <= i_entry_beats;
        end
        if (go) begin
            r_out_res <= res;
            r_out_pos <= pos;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_tone_level    = r_out_res.level;
    assign o_song_position = r_out_pos;
    assign o_current_note  = r_out_res.note;
    assign o_beat_event    = r_out_res.beat;

endmodule

// ===== hdl/mts_ram.sv =====
module mts_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mts_cfg.sv =====
module mts_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mts_pkg::t_cfg                   o_cfg,
    output logic                            o_hold
);
    import mts_pkg::*;

    t_cfg r_cfg;
    logic r_hold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.divider <= DIV_RST;
            r_cfg.length  <= LEN_RST;
            r_cfg.base    <= BASE_RST;
            r_hold        <= 1'b0;
        end else begin
            // the song prefetch lags the length register: hold the input word after each write
            r_hold <= i_cfg_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BEAT_DIVIDER: r_cfg.divider <= i_cfg_data[DIV_W-1:0];
                    CFG_SONG_LENGTH:  r_cfg.length  <= i_cfg_data[LEN_W-1:0];
                    CFG_BEAT_BASE:    r_cfg.base    <= i_cfg_data[TMR_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    assign o_cfg  = r_cfg;
    assign o_hold = r_hold;

endmodule

// ===== hdl/mts_core.sv =====
module mts_core #(
    parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  mts_pkg::t_item                i_item,
    input  mts_pkg::t_cfg                 i_cfg,
    output mts_pkg::t_result              o_res,
    output logic [$clog2(SONG_DEPTH)-1:0] o_pos
);
    import mts_pkg::*;

    localparam int PW = $clog2(SONG_DEPTH);
    localparam int CW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

    logic [TMR_W-1:0]   r_beat_timer, n_beat_timer;
    logic [DIV_W-1:0]   r_ovf_cnt, n_ovf_cnt;
    logic [BEATS_W-1:0] r_beats_left, n_beats_left;
    logic [PW-1:0]      r_pos, n_pos;
    logic [TMR_W-1:0]   r_tone_timer, n_tone_timer;
    logic               r_level, n_level;
    logic [NOTE_W-1:0]  r_cur, n_cur;
    t_entry             r_e0, n_e0;
    logic               r_byp_vld;
    t_entry             r_byp_data;

    logic [DIV_W-1:0]   ovf_inc;
    logic               beat;
    logic [CW-1:0]      idx_ext;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    t_entry             wr_data;
    logic [PW-1:0]      rd_addr;
    t_entry             ram_q;
    t_entry             nxt_entry;

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p,
                                                input logic [LEN_W-1:0] len);
        logic [CW-1:0] s;
        s = CW'(p) + CW'(1);
        if (s >= CW'(len) || s >= CW'(SONG_DEPTH)) begin
            return '0;
        end
        return s[PW-1:0];
    endfunction

    assign idx_ext      = CW'(i_item.idx);
    assign wr_addr      = idx_ext[PW-1:0];
    assign wr_data.note  = i_item.note;
    assign wr_data.beats = i_item.beats;
    assign wr_en = i_go && (i_item.kind == KIND_WRITE) && (idx_ext < CW'(SONG_DEPTH));

    // entry after the position that holds once this cycle is done
    assign rd_addr   = wrap_next(n_pos, i_cfg.length);
    assign nxt_entry = r_byp_vld ? r_byp_data : ram_q;
    assign ovf_inc   = r_ovf_cnt + DIV_W'(1);

    mts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SONG_DEPTH)
    ) u_song (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_beat_timer = r_beat_timer;
        n_ovf_cnt    = r_ovf_cnt;
        n_beats_left = r_beats_left;
        n_pos        = r_pos;
        n_tone_timer = r_tone_timer;
        n_level      = r_level;
        n_cur        = r_cur;
        n_e0         = r_e0;
        beat         = 1'b0;
        if (i_go) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (r_beat_timer == TMR_MAX) begin
                        n_beat_timer = i_cfg.base;
                        n_ovf_cnt    = ovf_inc;
                        if (ovf_inc >= i_cfg.divider) begin
                            n_ovf_cnt = '0;
                            beat      = 1'b1;
                            if (r_beats_left != '0) begin
                                n_beats_left = r_beats_left - BEATS_W'(1);
                            end
                        end
                    end else begin
                        n_beat_timer = r_beat_timer + TMR_W'(1);
                    end
                    // reload from the note playing before this tick
                    if (r_tone_timer == TMR_MAX) begin
                        n_tone_timer = tone_rom(clamp_note(r_cur));
                        n_level      = ~r_level;
                    end else begin
                        n_tone_timer = r_tone_timer + TMR_W'(1);
                    end
                    if (n_beats_left == '0) begin
                        n_pos        = wrap_next(r_pos, i_cfg.length);
                        n_beats_left = nxt_entry.beats;
                        n_cur        = nxt_entry.note;
                    end
                end
                KIND_WRITE: begin
                    if (wr_en) begin
                        if (wr_addr == r_pos) begin
                            n_cur = i_item.note;
                        end
                        if (wr_addr == '0) begin
                            n_e0 = wr_data;
                        end
                    end
                end
                KIND_RESTART: begin
                    n_pos        = '0;
                    n_beats_left = r_e0.beats;
                    n_cur        = r_e0.note;
                    n_ovf_cnt    = '0;
                    n_beat_timer = i_cfg.base;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_timer <= BASE_RST;
            r_ovf_cnt    <= '0;
            r_beats_left <= '0;
            r_pos        <= '0;
            r_tone_timer <= '0;
            r_level      <= 1'b0;
            r_byp_vld    <= 1'b0;
        end else begin
            r_beat_timer <= n_beat_timer;
            r_ovf_cnt    <= n_ovf_cnt;
            r_beats_left <= n_beats_left;
            r_pos        <= n_pos;
            r_tone_timer <= n_tone_timer;
            r_level      <= n_level;
            // RAM returns old data on a same-address write: forward it
            r_byp_vld    <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_e0       <= n_e0;
        r_byp_data <= wr_data;
    end

    assign o_res.level = n_level;
    assign o_res.note  = clamp_note(n_cur);
    assign o_res.beat  = beat;
    assign o_pos       = n_pos;

endmodule

// ===== verif/mts_player_checker.sv =====
`timescale 1ns / 1ps

module mts_player_checker #(
    parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEF,
    parameter int POS_W      = $clog2(SONG_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [mts_pkg::KIND_W-1:0]     i_kind,
    input  logic [mts_pkg::IDX_W-1:0]      i_entry_index,
    input  logic [mts_pkg::NOTE_W-1:0]     i_entry_note,
    input  logic [mts_pkg::BEATS_W-1:0]    i_entry_beats,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_tone_level,
    input  logic [POS_W-1:0]               i_song_position,
    input  logic [mts_pkg::NOTE_W-1:0]     i_current_note,
    input  logic                           i_beat_event,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import mts_pkg::*;

    // tone counter reload for each note
    localparam logic [TMR_W-1:0] PITCH_RELOAD [0:35] = '{
        16'hEFA9, 16'hF093, 16'hF173, 16'hF249, 16'hF307, 16'hF3C8,
        16'hF473, 16'hF51E, 16'hF5B6, 16'hF64C, 16'hF6D7, 16'hF75A,
        16'hF7D8, 16'hF84D, 16'hF8BD, 16'hF924, 16'hF987, 16'hF9E4,
        16'hFA3D, 16'hFA90, 16'hFADE, 16'hFB29, 16'hFB6F, 16'hFBB1,
        16'hFBEF, 16'hFC2A, 16'hFC62, 16'hFC95, 16'hFCC7, 16'hFCF6,
        16'hFD22, 16'hFD4B, 16'hFD73, 16'hFD98, 16'hFDBB, 16'hFDDC
    };

    typedef struct packed {
        logic              level;
        logic [POS_W-1:0]  pos;
        logic [NOTE_W-1:0] note;
        logic              beat;
    } t_play;

    logic [DIV_W-1:0]   div_r;
    logic [LEN_W-1:0]   len_r;
    logic [TMR_W-1:0]   base_r;
    logic [TMR_W-1:0]   beat_tmr;
    logic [TMR_W-1:0]   tone_tmr;
    logic [DIV_W-1:0]   ovf_cnt;
    logic [BEATS_W-1:0] beats_rem;
    logic [POS_W-1:0]   pos;
    logic               lvl;
    t_entry             melody [SONG_DEPTH];
    t_play              player_states_q [$];
    int                 fail_cnt = 0;
    int                 pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_cnt++;
    endtask

    function automatic logic [NOTE_W-1:0] playing_note();
        logic [NOTE_W-1:0] n;
        n = melody[pos].note;
        if (n >= NOTE_LIM)
            n = NOTE_W'(NOTE_LIM - 1);
        return n;
    endfunction

    task automatic advance_player(input logic [KIND_W-1:0] kind,
                                  input logic [IDX_W-1:0] w_idx,
                                  input logic [NOTE_W-1:0] w_note,
                                  input logic [BEATS_W-1:0] w_beats);
        int   nxt;
        logic beat;
        beat = 1'b0;
        case (kind)
            KIND_TICK: begin
                // beat timer first, then the tone counter on the old note
                if (beat_tmr == TMR_MAX) begin
                    beat_tmr = base_r;
                    ovf_cnt  = ovf_cnt + 1'b1;
                    if (ovf_cnt >= div_r) begin
                        ovf_cnt = '0;
                        beat    = 1'b1;
                        if (beats_rem != 0)
                            beats_rem = beats_rem - 1'b1;
                    end
                end else begin
                    beat_tmr = beat_tmr + 1'b1;
                end
                if (tone_tmr == TMR_MAX) begin
                    tone_tmr = PITCH_RELOAD[playing_note()];
                    lvl      = ~lvl;
                end else begin
                    tone_tmr = tone_tmr + 1'b1;
                end
                if (beats_rem == 0) begin
                    nxt = int'(pos) + 1;
                    if (nxt >= int'(len_r) || nxt >= SONG_DEPTH)
                        nxt = 0;
                    pos       = POS_W'(nxt);
                    beats_rem = melody[pos].beats;
                end
            end
            KIND_WRITE: begin
                if (int'(w_idx) < SONG_DEPTH)
                    melody[w_idx] = '{note: w_note, beats: w_beats};
            end
            KIND_RESTART: begin
                pos       = '0;
                beats_rem = melody[0].beats;
                ovf_cnt   = '0;
                beat_tmr  = base_r;
            end
            default: ;
        endcase
        player_states_q.push_back('{level: lvl, pos: pos, note: playing_note(), beat: beat});
    endtask

    always @(posedge i_clk) begin
        t_play got;
        t_play want;
        if (!i_rst_n) begin
            div_r     = DIV_RST;
            len_r     = LEN_RST;
            base_r    = BASE_RST;
            beat_tmr  = BASE_RST;
            tone_tmr  = '0;
            ovf_cnt   = '0;
            beats_rem = '0;
            pos       = '0;
            lvl       = 1'b0;
            player_states_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BEAT_DIVIDER: div_r  = i_cfg_data[DIV_W-1:0];
                    CFG_SONG_LENGTH:  len_r  = i_cfg_data[LEN_W-1:0];
                    CFG_BEAT_BASE:    base_r = i_cfg_data[TMR_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest word before queueing the new one
            if (i_out_valid && !i_out_stall) begin
                got = '{level: i_tone_level, pos: i_song_position,
                        note: i_current_note, beat: i_beat_event};
                if (player_states_q.size() == 0) begin
                    report_mismatch("output word with none pending", 16'd1, 16'd0);
                end else begin
                    want = player_states_q.pop_front();
                    if (got.level !== want.level)
                        report_mismatch("tone_level", 16'(got.level), 16'(want.level));
                    if (got.pos !== want.pos)
                        report_mismatch("song_position", 16'(got.pos), 16'(want.pos));
                    if (got.note !== want.note)
                        report_mismatch("current_note", 16'(got.note), 16'(want.note));
                    if (got.beat !== want.beat)
                        report_mismatch("beat_event", 16'(got.beat), 16'(want.beat));
                end
            end
            if (i_in_valid && !i_in_stall)
                advance_player(i_kind, i_entry_index, i_entry_note, i_entry_beats);
        end
        pending_cnt = player_states_q.size();
    end

endmodule

// ===== verif/tb_melody_tone_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_melody_tone_sequencer_core;
    import mts_pkg::*;

    localparam int SONG_DEPTH = SONG_DEPTH_DEF;
    localparam int POS_W      = $clog2(SONG_DEPTH);

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 60;
    localparam int LONG_PLAY_TICKS = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind;
    logic [IDX_W-1:0]      i_entry_index;
    logic [NOTE_W-1:0]     i_entry_note;
    logic [BEATS_W-1:0]    i_entry_beats;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_tone_level;
    logic [POS_W-1:0]      o_song_position;
    logic [NOTE_W-1:0]     o_current_note;
    logic                  o_beat_event;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   fail_count;
    int   pending;
    int   cycles;
    logic calm;
    logic hold_req;

    melody_tone_sequencer_core #(
        .SONG_DEPTH (SONG_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_entry_note    (i_entry_note),
        .i_entry_beats   (i_entry_beats),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tone_level    (o_tone_level),
        .o_song_position (o_song_position),
        .o_current_note  (o_current_note),
        .o_beat_event    (o_beat_event),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    mts_player_checker #(
        .SONG_DEPTH (SONG_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_entry_note    (i_entry_note),
        .i_entry_beats   (i_entry_beats),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_tone_level    (o_tone_level),
        .i_song_position (o_song_position),
        .i_current_note  (o_current_note),
        .i_beat_event    (o_beat_event),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // output side: random stall, or one long hold-off on request
    initial begin
        logic hold_done;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [KIND_W-1:0] kind, input int idx, input int note,
                             input int beats);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= IDX_W'(idx);
        i_entry_note  <= NOTE_W'(note);
        i_entry_beats <= BEATS_W'(beats);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drain every pending word, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_setting(input int div, input int len, input int base);
        settle();
        write_reg(CFG_BEAT_DIVIDER, div);
        write_reg(CFG_SONG_LENGTH, len);
        write_reg(CFG_BEAT_BASE, base);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_burst(input int n);
        int pick;
        int beats;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_word(KIND_TICK, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255));
            end else if (pick < 88) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    beats = $urandom_range(1, 3);
                else if (pick < 70)
                    beats = 0;
                else if (pick < 80)
                    beats = 255;
                else
                    beats = $urandom_range(0, 255);
                send_word(KIND_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), beats);
            end else if (pick < 94) begin
                send_word(KIND_RESTART, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255));
            end else begin
                send_word(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_TICK;
        i_entry_index = '0;
        i_entry_note  = '0;
        i_entry_beats = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BEAT_DIVIDER;
        i_cfg_data    = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill the whole song store, entry 0 first, before anything reads it
        for (int i = 0; i < SONG_DEPTH; i++)
            send_word(KIND_WRITE, i, $urandom_range(0, 63), $urandom_range(1, 3));

        load_setting(0, 4, 16'hFFFC);
        // beats left is still zero from reset: the first tick advances at once
        send_word(KIND_TICK, 0, 0, 0);
        send_word(KIND_TICK, 63, 63, 255);
        send_word(KIND_RESTART, 0, 0, 0);
        repeat (6) send_word(KIND_TICK, 0, 0, 0);
        send_word(KIND_WRITE, 1, 63, 0);
        send_word(KIND_WRITE, 2, 35, 255);
        send_word(KIND_WRITE, 63, 0, 1);
        send_word(KIND_UNUSED, 63, 63, 255);
        send_word(KIND_RESTART, 0, 0, 0);
        repeat (6) send_word(KIND_TICK, 0, 0, 0);
        send_word(KIND_WRITE, 2, 36, 1);
        repeat (3) send_word(KIND_TICK, 0, 0, 0);

        load_setting(0, 1, 16'hFFFF);
        random_burst(100);
        load_setting(255, 64, 16'hFFFE);
        random_burst(100);
        load_setting(1, 0, 16'hFFF8);
        random_burst(100);
        load_setting(3, 127, 16'h0000);
        random_burst(100);

        load_setting($urandom_range(0, 7), $urandom_range(1, 64),
                     $urandom_range(16'hFFF0, 16'hFFFF));
        random_burst(20);
        // hold the output while words keep coming, so the input backs up
        hold_req = 1'b1;
        random_burst(110);

        // long run of ticks, no idling on either side
        load_setting(2, 64, 16'hFFFF);
        calm = 1'b1;
        repeat (LONG_PLAY_TICKS) send_word(KIND_TICK, 0, 0, 0);
        calm = 1'b0;

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
